@@ rtl/lidar_scan_to_world_points_defines.svh @@
// Assertion macros shared by the scan-to-world RTL files.
`ifndef LIDAR_SCAN_TO_WORLD_POINTS_DEFINES_SVH
`define LIDAR_SCAN_TO_WORLD_POINTS_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define LSW_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define LSW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/lsw_pkg.sv @@
// Shared constants, types and the arctangent table for the scan-to-world block.
`timescale 1ns / 1ps

package lsw_pkg;

    localparam int SCAN_POINTS  = 228;
    localparam int WINDOW_WIDTH = 5;
    localparam int CORDIC_STEPS = 16;

    // Beam angle in 1024ths of a turn: step*index + base - center, wrapped
    localparam int BEAM_STEP   = 3;
    localparam int BEAM_BASE   = 44;
    localparam int BEAM_CENTER = 384;
    localparam int BEAM_TURN   = 1024;
    localparam int BEAM_OFFSET = (BEAM_BASE - BEAM_CENTER + BEAM_TURN) % BEAM_TURN;

    localparam int CFG_W     = 24;
    localparam int CFG_IDX_W = 3;
    localparam int POS_W     = 24;
    localparam int MOUNT_W   = 16;
    localparam int HEAD_W    = 16;
    localparam int BEAM_W    = 10;
    localparam int DIST_W    = 16;

    localparam int ANG_W    = 34;  // CORDIC residual angle, 2^32 per turn plus headroom
    localparam int TRIG_W   = 33;  // Q30 sine and cosine with headroom
    localparam int MUL_A_W  = 18;
    localparam int PROD_W   = MUL_A_W + TRIG_W;
    localparam int ACC_W    = 26;
    localparam int Q_SHIFT  = 30;
    localparam int ATAN_ENTRIES = 24;
    localparam int ATAN_IW  = $clog2(ATAN_ENTRIES);
    localparam int ATAN_W   = 30;

    localparam logic [ATAN_IW-1:0] LAST_ITER = ATAN_IW'(CORDIC_STEPS - 1);
    localparam logic signed [TRIG_W-1:0] CORDIC_GAIN_Q30 = 33'sd652032874;
    localparam logic [HEAD_W-1:0] HALF_TURN16 = 16'h8000;

    localparam logic signed [POS_W-1:0] POS_MAX = 24'sh7FFFFF;
    localparam logic signed [POS_W-1:0] POS_MIN = 24'sh800000;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ROBOT_X     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROBOT_Y     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADING     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MOUNT_FWD   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MOUNT_SIDE  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SIDE_START  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_FRONT_START = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_CAP         = 3'd7;

    localparam logic signed [MOUNT_W-1:0] RST_MOUNT_FWD = 16'sd597;
    localparam logic [BEAM_W-1:0] RST_SIDE_START  = 10'd52;
    localparam logic [BEAM_W-1:0] RST_FRONT_START = 10'd111;
    localparam logic [DIST_W-1:0] RST_CAP         = 16'd38912;

    typedef struct packed {
        logic busy;
        logic done;
    } t_cor_status;

    typedef struct packed {
        logic load;   // preset both accumulators
        logic issue;  // capture a product this cycle
        logic dst_y;  // product goes to the y accumulator
    } t_mac_ctrl;

    // atan(2^-i) in 2^32 per turn
    function automatic logic [ATAN_W-1:0] atan_turn32(input logic [ATAN_IW-1:0] idx);
        logic [ATAN_W-1:0] v;
        case (idx)
            5'd0:    v = 30'd536870912;
            5'd1:    v = 30'd316933406;
            5'd2:    v = 30'd167458907;
            5'd3:    v = 30'd85004756;
            5'd4:    v = 30'd42667331;
            5'd5:    v = 30'd21354465;
            5'd6:    v = 30'd10679838;
            5'd7:    v = 30'd5340245;
            5'd8:    v = 30'd2670163;
            5'd9:    v = 30'd1335087;
            5'd10:   v = 30'd667544;
            5'd11:   v = 30'd333772;
            5'd12:   v = 30'd166886;
            5'd13:   v = 30'd83443;
            5'd14:   v = 30'd41722;
            5'd15:   v = 30'd20861;
            5'd16:   v = 30'd10430;
            5'd17:   v = 30'd5215;
            5'd18:   v = 30'd2608;
            5'd19:   v = 30'd1304;
            5'd20:   v = 30'd652;
            5'd21:   v = 30'd326;
            5'd22:   v = 30'd163;
            5'd23:   v = 30'd81;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

@@ rtl/lsw_cordic.sv @@
// Iterative rotation-mode CORDIC giving Q30 sine and cosine of a 16-bit binary angle.
`timescale 1ns / 1ps
`include "lidar_scan_to_world_points_defines.svh"

module lsw_cordic (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic [lsw_pkg::HEAD_W-1:0]          i_angle,
    output lsw_pkg::t_cor_status                o_status,
    output logic signed [lsw_pkg::TRIG_W-1:0]   o_cos,
    output logic signed [lsw_pkg::TRIG_W-1:0]   o_sin
);
    import lsw_pkg::*;

    logic signed [TRIG_W-1:0] r_x, r_y;
    logic signed [ANG_W-1:0]  r_z;
    logic [ATAN_IW-1:0]       r_iter;
    logic                     r_flip, r_busy, r_done;

    logic                     fold;
    logic [HEAD_W-1:0]        folded;
    logic signed [ANG_W-1:0]  z_start, atan_step;
    logic signed [TRIG_W-1:0] x_sh, y_sh, n_x, n_y;
    logic signed [ANG_W-1:0]  n_z;

    // Second and third quadrants rotate by a half turn and negate at the end
    assign fold    = (i_angle[HEAD_W-1:HEAD_W-2] == 2'b01) ||
                     (i_angle[HEAD_W-1:HEAD_W-2] == 2'b10);
    assign folded  = fold ? (i_angle ^ HALF_TURN16) : i_angle;
    assign z_start = ANG_W'(signed'({folded, 16'b0}));
    assign atan_step = $signed({{(ANG_W-ATAN_W){1'b0}}, atan_turn32(r_iter)});

    assign x_sh = r_x >>> r_iter;
    assign y_sh = r_y >>> r_iter;

    always_comb begin
        if (!r_z[ANG_W-1]) begin
            n_x = r_x - y_sh;
            n_y = r_y + x_sh;
            n_z = r_z - atan_step;
        end else begin
            n_x = r_x + y_sh;
            n_y = r_y - x_sh;
            n_z = r_z + atan_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_iter <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_iter <= '0;
            end else if (r_busy) begin
                r_iter <= r_iter + 1'b1;
                if (r_iter == LAST_ITER) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x    <= CORDIC_GAIN_Q30;
            r_y    <= '0;
            r_z    <= z_start;
            r_flip <= fold;
        end else if (r_busy) begin
            r_x <= n_x;
            r_y <= n_y;
            r_z <= n_z;
        end
    end

    assign o_cos = r_flip ? -r_x : r_x;
    assign o_sin = r_flip ? -r_y : r_y;
    assign o_status.busy = r_busy;
    assign o_status.done = r_done;

    `LSW_ASSERT_NOW(a_no_restart, i_clk, i_rst_n, i_start, !r_busy, "start while rotating")
    `LSW_ASSERT_NEXT(a_done_after_last, i_clk, i_rst_n,
        i_rst_n && r_busy && !i_start && (r_iter == LAST_ITER), r_done && !r_busy,
        "last iteration did not finish")

endmodule

@@ rtl/lsw_mac.sv @@
// Shared multiplier with Q30 rounding and the x and y point accumulators.
`timescale 1ns / 1ps

module lsw_mac (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  lsw_pkg::t_mac_ctrl                  i_ctrl,
    input  logic signed [lsw_pkg::ACC_W-1:0]    i_init_x,
    input  logic signed [lsw_pkg::ACC_W-1:0]    i_init_y,
    input  logic signed [lsw_pkg::MUL_A_W-1:0]  i_a,
    input  logic signed [lsw_pkg::TRIG_W-1:0]   i_b,
    output logic signed [lsw_pkg::ACC_W-1:0]    o_acc_x,
    output logic signed [lsw_pkg::ACC_W-1:0]    o_acc_y
);
    import lsw_pkg::*;

    localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(1) <<< (Q_SHIFT - 1);

    logic signed [PROD_W-1:0] r_prod;
    logic                     r_pend, r_pend_y;
    logic signed [ACC_W-1:0]  r_acc_x, r_acc_y;

    logic signed [PROD_W-1:0] rounded, shifted;
    logic signed [ACC_W-1:0]  term;

    // Round half up, then floor shift
    assign rounded = r_prod + ROUND_HALF;
    assign shifted = rounded >>> Q_SHIFT;
    assign term    = shifted[ACC_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend   <= 1'b0;
            r_pend_y <= 1'b0;
        end else begin
            r_pend   <= i_ctrl.issue;
            r_pend_y <= i_ctrl.dst_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.issue) begin
            r_prod <= i_a * i_b;
        end
        if (i_ctrl.load) begin
            r_acc_x <= i_init_x;
            r_acc_y <= i_init_y;
        end else if (r_pend) begin
            if (r_pend_y) begin
                r_acc_y <= r_acc_y + term;
            end else begin
                r_acc_x <= r_acc_x + term;
            end
        end
    end

    assign o_acc_x = r_acc_x;
    assign o_acc_y = r_acc_y;

endmodule

@@ rtl/lidar_scan_to_world_points.sv @@
// Top level: ranging sample to world point, with windowed scan minima.
`timescale 1ns / 1ps
`include "lidar_scan_to_world_points_defines.svh"

// Turns one ranging sample (beam index, distance) into a saturated world x,y
// point and reports the running side and front window minima of the scan.
// A single iterative CORDIC rotator is run twice per item, once for the robot
// heading and once for the beam angle plus heading, and one shared multiplier
// forms the four Q30 products. The input is not ready while an item is being
// worked and comes ready again in the cycle the result appears, so a new item
// is taken only once the last one is through.
// A finished result waits in the output register while the next item is
// accepted, and a stalled output adds cycles only when a second result is
// ready before the first is taken. Register writes are expected while idle; a
// new distance_cap takes effect at the next beam 0.
module lidar_scan_to_world_points (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [lsw_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [lsw_pkg::CFG_W-1:0]            i_cfg_data,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic [lsw_pkg::BEAM_W-1:0]           i_beam_index,
    input  logic [lsw_pkg::DIST_W-1:0]           i_distance,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic signed [lsw_pkg::POS_W-1:0]     o_point_x,
    output logic signed [lsw_pkg::POS_W-1:0]     o_point_y,
    output logic [lsw_pkg::DIST_W-1:0]           o_side_minimum,
    output logic [lsw_pkg::DIST_W-1:0]           o_front_minimum
);
    import lsw_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE = 9'b0_0000_0001,
        S_CH   = 9'b0_0000_0010,
        S_MX   = 9'b0_0000_0100,
        S_MY   = 9'b0_0000_1000,
        S_CA   = 9'b0_0001_0000,
        S_DX   = 9'b0_0010_0000,
        S_DY   = 9'b0_0100_0000,
        S_FIN  = 9'b0_1000_0000,
        S_OUT  = 9'b1_0000_0000
    } t_state;

    t_state r_state, n_state;

    logic signed [POS_W-1:0]   r_robot_x, r_robot_y;
    logic [HEAD_W-1:0]         r_heading;
    logic signed [MOUNT_W-1:0] r_mount_fwd, r_mount_side;
    logic [BEAM_W-1:0]         r_side_start, r_front_start;
    logic [DIST_W-1:0]         r_cap;

    logic [DIST_W-1:0]         r_side_min, r_front_min;
    logic [BEAM_W-1:0]         r_idx;
    logic [DIST_W-1:0]         r_dist;

    logic                      r_out_valid;
    logic signed [POS_W-1:0]   r_point_x, r_point_y;
    logic [DIST_W-1:0]         r_side_out, r_front_out;

    logic                      accept;
    logic [BEAM_W:0]           idx_ext, side_end, front_end;
    logic                      in_scan, side_hit, front_hit;
    logic [DIST_W-1:0]         base_side, base_front;
    logic [BEAM_W+1:0]         beam_sum;
    logic [HEAD_W-1:0]         beam_ang;

    logic                      cor_start;
    logic [HEAD_W-1:0]         cor_angle;
    t_cor_status               cor_status;
    logic signed [TRIG_W-1:0]  cor_cos, cor_sin;

    t_mac_ctrl                 mac_ctrl;
    logic signed [MUL_A_W-1:0] mac_a, mount_sum, mount_diff, dist_ext;
    logic signed [TRIG_W-1:0]  mac_b;
    logic signed [ACC_W-1:0]   acc_x, acc_y;
    logic                      out_load;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;

    // Configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_robot_x     <= '0;
            r_robot_y     <= '0;
            r_heading     <= '0;
            r_mount_fwd   <= RST_MOUNT_FWD;
            r_mount_side  <= '0;
            r_side_start  <= RST_SIDE_START;
            r_front_start <= RST_FRONT_START;
            r_cap         <= RST_CAP;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_ROBOT_X:     r_robot_x     <= signed'(i_cfg_data[POS_W-1:0]);
                CFG_ROBOT_Y:     r_robot_y     <= signed'(i_cfg_data[POS_W-1:0]);
                CFG_HEADING:     r_heading     <= i_cfg_data[HEAD_W-1:0];
                CFG_MOUNT_FWD:   r_mount_fwd   <= signed'(i_cfg_data[MOUNT_W-1:0]);
                CFG_MOUNT_SIDE:  r_mount_side  <= signed'(i_cfg_data[MOUNT_W-1:0]);
                CFG_SIDE_START:  r_side_start  <= i_cfg_data[BEAM_W-1:0];
                CFG_FRONT_START: r_front_start <= i_cfg_data[BEAM_W-1:0];
                CFG_CAP:         r_cap         <= i_cfg_data[DIST_W-1:0];
                default: ;
            endcase
        end
    end

    // Window minima, settled when the item is taken; beam 0 restarts both
    assign idx_ext    = {1'b0, i_beam_index};
    assign in_scan    = idx_ext < (BEAM_W+1)'(SCAN_POINTS);
    assign side_end   = {1'b0, r_side_start} + (BEAM_W+1)'(WINDOW_WIDTH);
    assign front_end  = {1'b0, r_front_start} + (BEAM_W+1)'(WINDOW_WIDTH);
    assign base_side  = (i_beam_index == '0) ? r_cap : r_side_min;
    assign base_front = (i_beam_index == '0) ? r_cap : r_front_min;
    assign side_hit   = in_scan && (i_beam_index >= r_side_start) &&
                        (idx_ext < side_end) && (i_distance < base_side);
    assign front_hit  = in_scan && (i_beam_index >= r_front_start) &&
                        (idx_ext < front_end) && (i_distance < base_front);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side_min  <= RST_CAP;
            r_front_min <= RST_CAP;
        end else if (accept) begin
            r_side_min  <= side_hit ? i_distance : base_side;
            r_front_min <= front_hit ? i_distance : base_front;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_idx  <= i_beam_index;
            r_dist <= i_distance;
        end
    end

    // Beam angle in 1024ths of a turn, widened to the 16-bit heading scale and added to the heading
    assign beam_sum = ({2'b0, r_idx} * (BEAM_W+2)'(BEAM_STEP)) + (BEAM_W+2)'(BEAM_OFFSET);
    assign beam_ang = {beam_sum[BEAM_W-1:0], {(HEAD_W-BEAM_W){1'b0}}} + r_heading;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (i_in_valid) n_state = S_CH;
            S_CH:    if (cor_status.done) n_state = S_MX;
            S_MX:    n_state = S_MY;
            S_MY:    n_state = S_CA;
            S_CA:    if (cor_status.done) n_state = S_DX;
            S_DX:    n_state = S_DY;
            S_DY:    n_state = S_FIN;
            S_FIN:   n_state = S_OUT;
            S_OUT:   if (out_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Heading rotation starts with the item, beam rotation once the heading
    // products are issued
    assign cor_start = accept || (r_state == S_MY);
    assign cor_angle = (r_state == S_IDLE) ? r_heading : beam_ang;

    lsw_cordic u_cordic (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (cor_start),
        .i_angle  (cor_angle),
        .o_status (cor_status),
        .o_cos    (cor_cos),
        .o_sin    (cor_sin)
    );

    assign mount_sum  = MUL_A_W'(r_mount_fwd) + MUL_A_W'(r_mount_side);
    assign mount_diff = MUL_A_W'(r_mount_fwd) - MUL_A_W'(r_mount_side);
    assign dist_ext   = signed'({{(MUL_A_W-DIST_W){1'b0}}, r_dist});

    always_comb begin
        case (r_state)
            S_MX:    mac_a = mount_sum;
            S_MY:    mac_a = mount_diff;
            default: mac_a = dist_ext;
        endcase
    end

    assign mac_b = ((r_state == S_MX) || (r_state == S_DX)) ? cor_cos : cor_sin;

    assign mac_ctrl.load  = accept;
    assign mac_ctrl.issue = (r_state == S_MX) || (r_state == S_MY) ||
                            (r_state == S_DX) || (r_state == S_DY);
    assign mac_ctrl.dst_y = (r_state == S_MY) || (r_state == S_DY);

    lsw_mac u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (mac_ctrl),
        .i_init_x (ACC_W'(r_robot_x)),
        .i_init_y (ACC_W'(r_robot_y)),
        .i_a      (mac_a),
        .i_b      (mac_b),
        .o_acc_x  (acc_x),
        .o_acc_y  (acc_y)
    );

    function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [ACC_W-1:0] v);
        logic signed [POS_W-1:0] r;
        if (v > ACC_W'(POS_MAX)) begin
            r = POS_MAX;
        end else if (v < ACC_W'(POS_MIN)) begin
            r = POS_MIN;
        end else begin
            r = v[POS_W-1:0];
        end
        return r;
    endfunction

    // Output register: load when empty or being drained
    assign out_load = (r_state == S_OUT) && (!r_out_valid || i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_point_x   <= sat_pos(acc_x);
            r_point_y   <= sat_pos(acc_y);
            r_side_out  <= r_side_min;
            r_front_out <= r_front_min;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_point_x       = r_point_x;
    assign o_point_y       = r_point_y;
    assign o_side_minimum  = r_side_out;
    assign o_front_minimum = r_front_out;

    `LSW_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_rst_n && accept, !o_in_ready,
        "input ready right after an item was taken")
    `LSW_ASSERT_NEXT(a_min_hold, i_clk, i_rst_n, i_rst_n && !accept,
        $stable(r_side_min) && $stable(r_front_min), "minimum moved without an item")
    `LSW_ASSERT_NOW(a_done_in_wait, i_clk, i_rst_n, cor_status.done,
        (r_state == S_CH) || (r_state == S_CA), "rotation finished outside a wait state")
    `LSW_ASSERT_NOW(a_idle_rotator, i_clk, i_rst_n, o_in_ready, !cor_status.busy,
        "rotator busy while idle")

endmodule

@@ dv/tb_top.sv @@
// Self-checking testbench for lidar_scan_to_world_points: directed and random ranging samples.
`timescale 1ns / 1ps

module tb_top;
    import lsw_pkg::*;

    typedef struct packed {
        logic [BEAM_W-1:0] beam;
        logic [DIST_W-1:0] range_q;
    } sample_t;

    typedef struct packed {
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic [DIST_W-1:0]       side_min;
        logic [DIST_W-1:0]       front_min;
    } point_t;

    localparam longint ROT_GAIN_Q30 = 652032874;
    localparam int STALL_LIMIT = 2000;
    localparam int TAIL_CYCLES = 2 * CORDIC_STEPS + 20;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]    i_cfg_index = '0;
    logic [CFG_W-1:0]        i_cfg_data = '0;
    logic                    i_in_valid = 1'b0;
    logic                    o_in_ready;
    logic [BEAM_W-1:0]       i_beam_index = '0;
    logic [DIST_W-1:0]       i_distance = '0;
    logic                    o_out_valid;
    logic                    i_out_ready = 1'b0;
    logic signed [POS_W-1:0] o_point_x;
    logic signed [POS_W-1:0] o_point_y;
    logic [DIST_W-1:0]       o_side_minimum;
    logic [DIST_W-1:0]       o_front_minimum;

    // Shadow of the register file and the scan minima
    logic signed [POS_W-1:0]   m_robot_x = '0;
    logic signed [POS_W-1:0]   m_robot_y = '0;
    logic [HEAD_W-1:0]         m_heading = '0;
    logic signed [MOUNT_W-1:0] m_fwd = RST_MOUNT_FWD;
    logic signed [MOUNT_W-1:0] m_side = '0;
    logic [BEAM_W-1:0]         m_side_start = RST_SIDE_START;
    logic [BEAM_W-1:0]         m_front_start = RST_FRONT_START;
    logic [DIST_W-1:0]         m_cap = RST_CAP;
    logic [DIST_W-1:0]         m_side_min = RST_CAP;
    logic [DIST_W-1:0]         m_front_min = RST_CAP;

    longint atan_q32 [0:23] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861, 10430, 5215,
        2608, 1304, 652, 326, 163, 81
    };

    sample_t pending_samples[$];
    point_t  predicted_points[$];
    logic    in_taken = 1'b0;
    logic    steady = 1'b0;
    int      mismatches = 0;
    int      quiet_cycles = 0;
    int      queued_total = 0;
    int      last_dist = 0;

    lidar_scan_to_world_points DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_beam_index    (i_beam_index),
        .i_distance      (i_distance),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_point_x       (o_point_x),
        .o_point_y       (o_point_y),
        .o_side_minimum  (o_side_minimum),
        .o_front_minimum (o_front_minimum)
    );

    always #5 i_clk = ~i_clk;

    // Rotation-mode CORDIC, Q30 cosine and sine of a 2^32-per-turn angle
    function automatic void rotate_unit(input logic [31:0] ang, output longint c,
                                        output longint s);
        longint x;
        longint y;
        longint z;
        longint nx;
        logic [31:0] a;
        logic flip;
        a = ang;
        // fold the left half plane by a half turn, negate both at the end
        flip = (a[31:30] == 2'b01) || (a[31:30] == 2'b10);
        if (flip)
            a = a - 32'h8000_0000;
        x = ROT_GAIN_Q30;
        y = 0;
        z = longint'($signed(a));
        for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
            if (z >= 0) begin
                nx = x - (y >>> i);
                y = y + (x >>> i);
                z = z - atan_q32[i];
            end else begin
                nx = x + (y >>> i);
                y = y - (x >>> i);
                z = z + atan_q32[i];
            end
            x = nx;
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    function automatic longint scale_q30(input longint a, input longint t);
        return (a * t + 64'sd536870912) >>> 30;
    endfunction

    function automatic logic signed [POS_W-1:0] clamp_pos(input longint v);
        if (v > 64'sd8388607)
            return POS_MAX;
        if (v < -64'sd8388608)
            return POS_MIN;
        return v[POS_W-1:0];
    endfunction

    function automatic bit in_span(input logic [BEAM_W-1:0] b, input logic [BEAM_W-1:0] start);
        return int'(b) >= int'(start) && int'(b) < int'(start) + WINDOW_WIDTH;
    endfunction

    // World point of one sample; advances the scan minima
    function automatic point_t project_sample(input sample_t s);
        longint ch;
        longint sh;
        longint ca;
        longint sa;
        longint px;
        longint py;
        logic [15:0] beam_ang;
        logic [15:0] ray_ang;
        point_t p;
        rotate_unit({m_heading, 16'h0000}, ch, sh);
        beam_ang = 16'((int'(s.beam) * BEAM_STEP + BEAM_BASE) * 64 + 65536 - BEAM_CENTER * 64);
        ray_ang = beam_ang + m_heading;
        rotate_unit({ray_ang, 16'h0000}, ca, sa);
        px = longint'(m_robot_x) + scale_q30(longint'(m_fwd) + longint'(m_side), ch)
             + scale_q30(longint'(s.range_q), ca);
        py = longint'(m_robot_y) + scale_q30(longint'(m_fwd) - longint'(m_side), sh)
             + scale_q30(longint'(s.range_q), sa);
        if (s.beam == '0) begin
            m_side_min = m_cap;
            m_front_min = m_cap;
        end
        if (int'(s.beam) < SCAN_POINTS) begin
            if (in_span(s.beam, m_side_start) && s.range_q < m_side_min)
                m_side_min = s.range_q;
            if (in_span(s.beam, m_front_start) && s.range_q < m_front_min)
                m_front_min = s.range_q;
        end
        p.x = clamp_pos(px);
        p.y = clamp_pos(py);
        p.side_min = m_side_min;
        p.front_min = m_front_min;
        return p;
    endfunction

    function automatic bit allow_move();
        return steady || ($urandom_range(0, 99) >= 10);
    endfunction

    // Driver: present the next item, hold it until taken
    always @(negedge i_clk) begin
        sample_t s;
        i_out_ready <= allow_move();
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_taken) begin
            if (pending_samples.size() > 0 && allow_move()) begin
                s = pending_samples.pop_front();
                i_in_valid <= 1'b1;
                i_beam_index <= s.beam;
                i_distance <= s.range_q;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Monitor: predict on input acceptance, compare on output acceptance
    always @(posedge i_clk) begin
        sample_t s;
        point_t got;
        point_t want;
        in_taken <= i_rst_n && i_in_valid && o_in_ready;
        if (i_rst_n && i_in_valid && o_in_ready) begin
            s.beam = i_beam_index;
            s.range_q = i_distance;
            predicted_points.push_back(project_sample(s));
        end
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got.x = o_point_x;
            got.y = o_point_y;
            got.side_min = o_side_minimum;
            got.front_min = o_front_minimum;
            if (predicted_points.size() == 0) begin
                mismatches = mismatches + 1;
                if (mismatches <= 10)
                    $display("unexpected point x=%0d y=%0d side=%0d front=%0d",
                             got.x, got.y, got.side_min, got.front_min);
            end else begin
                want = predicted_points.pop_front();
                if (got.x !== want.x || got.y !== want.y || got.side_min !== want.side_min
                        || got.front_min !== want.front_min) begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10)
                        $display("mismatch exp x=%0d y=%0d s=%0d f=%0d got x=%0d y=%0d s=%0d f=%0d",
                                 want.x, want.y, want.side_min, want.front_min,
                                 got.x, got.y, got.side_min, got.front_min);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        case (idx)
            CFG_ROBOT_X:     m_robot_x = val[POS_W-1:0];
            CFG_ROBOT_Y:     m_robot_y = val[POS_W-1:0];
            CFG_HEADING:     m_heading = val[HEAD_W-1:0];
            CFG_MOUNT_FWD:   m_fwd = val[MOUNT_W-1:0];
            CFG_MOUNT_SIDE:  m_side = val[MOUNT_W-1:0];
            CFG_SIDE_START:  m_side_start = val[BEAM_W-1:0];
            CFG_FRONT_START: m_front_start = val[BEAM_W-1:0];
            CFG_CAP:         m_cap = val[DIST_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic queue_sample(input int b, input int d);
        sample_t s;
        s.beam = BEAM_W'(b);
        s.range_q = DIST_W'(d);
        pending_samples.push_back(s);
        queued_total = queued_total + 1;
        last_dist = d;
    endtask

    function automatic int pick_distance();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4)
            return $urandom_range(0, 65535);
        if (r < 8)
            return $urandom_range(0, 3000);
        return last_dist;  // repeat, so equal values hit the minima
    endfunction

    // One well-formed scan: beam 0, both windows with a beam either side, a tail past the scan
    task automatic queue_scan();
        int lo;
        int hi;
        int b;
        lo = (m_side_start < m_front_start) ? int'(m_side_start) : int'(m_front_start);
        hi = (m_side_start < m_front_start) ? int'(m_front_start) : int'(m_side_start);
        queue_sample(0, pick_distance());
        for (b = lo - 1; b <= lo + WINDOW_WIDTH; b++)
            if (b >= 1 && b <= 1023)
                queue_sample(b, pick_distance());
        for (b = (hi - 1 > lo + WINDOW_WIDTH) ? hi - 1 : lo + WINDOW_WIDTH + 1;
                b <= hi + WINDOW_WIDTH; b++)
            if (b >= 1 && b <= 1023)
                queue_sample(b, pick_distance());
        repeat (2)
            queue_sample($urandom_range(SCAN_POINTS, 1023), pick_distance());
    endtask

    task automatic load_random_setup(input bit far_windows);
        logic [HEAD_W-1:0] hd;
        case ($urandom_range(0, 4))
            0:       hd = 16'h4000;
            1:       hd = 16'h8000;
            2:       hd = 16'hC000;
            default: hd = 16'($urandom);
        endcase
        set_reg(CFG_ROBOT_X, $urandom_range(0, 1) ? 24'($urandom)
                                                  : 24'($urandom_range(0, 200000) - 100000));
        set_reg(CFG_ROBOT_Y, $urandom_range(0, 1) ? 24'($urandom)
                                                  : 24'($urandom_range(0, 200000) - 100000));
        set_reg(CFG_HEADING, {8'($urandom), hd});
        set_reg(CFG_MOUNT_FWD, $urandom_range(0, 1) ? 24'($urandom)
                               : {8'($urandom), 16'($urandom_range(0, 4000) - 2000)});
        set_reg(CFG_MOUNT_SIDE, $urandom_range(0, 1) ? 24'($urandom)
                                : {8'($urandom), 16'($urandom_range(0, 4000) - 2000)});
        if (far_windows)
            set_reg(CFG_SIDE_START, {14'($urandom), 10'($urandom_range(1018, 1023))});
        else
            set_reg(CFG_SIDE_START, {14'($urandom), 10'($urandom_range(0, 230))});
        set_reg(CFG_FRONT_START, {14'($urandom), 10'($urandom_range(0, 230))});
        case ($urandom_range(0, 3))
            0:       set_reg(CFG_CAP, {8'($urandom), 16'd38912});
            1:       set_reg(CFG_CAP, {8'($urandom), 16'hFFFF});
            default: set_reg(CFG_CAP, 24'($urandom));
        endcase
    endtask

    task automatic wait_drained();
        while (pending_samples.size() != 0 || predicted_points.size() != 0 || i_in_valid)
            @(posedge i_clk);
    endtask

    initial begin
        int phase;
        int target;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: scan start, windows, equal value, past-scan beams
        queue_sample(0, 1000);
        queue_sample(52, 5000);
        queue_sample(53, 5000);
        queue_sample(56, 65535);
        queue_sample(57, 10);
        queue_sample(111, 0);
        queue_sample(115, 65535);
        queue_sample(227, 7);
        queue_sample(228, 0);
        queue_sample(1023, 65535);
        wait_drained();

        // new cap waits for the next beam 0
        set_reg(CFG_CAP, 24'd100);
        @(posedge i_clk);
        queue_sample(54, 3000);
        queue_sample(0, 65535);
        queue_sample(52, 100);
        wait_drained();

        // positive x and negative y extremes, side window above 1023
        set_reg(CFG_ROBOT_X, 24'h7FFFFF);
        set_reg(CFG_ROBOT_Y, 24'h800000);
        set_reg(CFG_HEADING, 24'hFF2000);
        set_reg(CFG_MOUNT_FWD, 24'h007FFF);
        set_reg(CFG_MOUNT_SIDE, 24'hAA8000);
        set_reg(CFG_SIDE_START, 24'h0003FC);
        set_reg(CFG_FRONT_START, 24'h000000);
        set_reg(CFG_CAP, 24'h00FFFF);
        @(posedge i_clk);
        queue_sample(0, 65535);
        queue_sample(4, 0);
        queue_sample(1021, 1);
        queue_sample(511, 65535);
        wait_drained();

        // opposite extremes, front window at the top beam, zero cap
        set_reg(CFG_ROBOT_X, 24'h800000);
        set_reg(CFG_ROBOT_Y, 24'h7FFFFF);
        set_reg(CFG_HEADING, 24'h00FFFF);
        set_reg(CFG_MOUNT_FWD, 24'h008000);
        set_reg(CFG_MOUNT_SIDE, 24'h007FFF);
        set_reg(CFG_SIDE_START, 24'h000000);
        set_reg(CFG_FRONT_START, 24'h0003FF);
        set_reg(CFG_CAP, 24'h000000);
        @(posedge i_clk);
        queue_sample(0, 0);
        queue_sample(3, 65535);
        queue_sample(700, 40000);
        queue_sample(341, 12345);
        wait_drained();

        for (phase = 0; phase < 6; phase++) begin
            load_random_setup(phase == 4);
            steady <= (phase == 2);
            @(posedge i_clk);
            target = queued_total + 200;
            while (queued_total < target) begin
                if ($urandom_range(0, 99) < 80)
                    queue_scan();
                else
                    queue_sample($urandom_range(0, 1023), $urandom_range(0, 65535));
            end
            wait_drained();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        mismatches = mismatches + predicted_points.size();
        if (mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/lsw_pkg.sv
rtl/lsw_cordic.sv
rtl/lsw_mac.sv
rtl/lidar_scan_to_world_points.sv
dv/tb_top.sv
